// ===== hw/rtl/wsg_pkg.sv =====
// Shared types and constants for the wavetable sample generator.
// Used by the divider, the sine unit and the top level; depends on nothing.
package wsg_pkg;

  // Sample format: signed Q1.15.
  localparam int SAMPLE_W  = 16;
  localparam int FRAC_BITS = SAMPLE_W - 1;
  localparam int INDEX_W   = 12;
  localparam int LEN_W     = 13;
  localparam logic [LEN_W-1:0] MAX_LEN = 13'd4096;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TABLE_LENGTH = 4'd0,
    REG_WAVE_SHAPE   = 4'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SHAPE_SINE   = 2'd0,
    SHAPE_SAW    = 2'd1,
    SHAPE_TRI    = 2'd2,
    SHAPE_SQUARE = 2'd3
  } wave_shape_t;

  // Pipelined divider: 32 quotient bits, two per stage.
  localparam int QUOT_W     = 32;
  localparam int DEN_W      = 14;
  localparam int NUM_W      = INDEX_W + QUOT_W;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = QUOT_W / DIV_STEPS;

  // Saw and triangle quotient width.
  localparam int LIN_W = FRAC_BITS + 2;

  // Sine series: Q30 fixed point and the nested Horner divisors.
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam int SER_LEN = 6;
  localparam int SER_K [SER_LEN] = '{156, 110, 72, 42, 20, 6};
  // Ceiling of log2 of each divisor.
  localparam int SER_L [SER_LEN] = '{8, 7, 7, 6, 5, 3};

  // Per-item sideband that travels with the data.
  typedef struct packed {
    logic              valid;
    logic              err;
    wave_shape_t       shape;
    logic              below_half;
    logic              rising;
    logic [LIN_W-1:0]  t;
  } item_t;

endpackage

// ===== hw/rtl/wsg_div.sv =====
// Pipelined restoring divider, two quotient bits per register stage.
// Depends on wsg_pkg; the dividend's top part must be below the divisor.
module wsg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  wsg_pkg::item_t              item_i,
  input  logic [wsg_pkg::NUM_W-1:0]   num_i,
  input  logic [wsg_pkg::DEN_W-1:0]   den_i,
  output wsg_pkg::item_t              item_o,
  output logic [wsg_pkg::QUOT_W-1:0]  quot_o
);
  import wsg_pkg::*;

  item_t             item_r [DIV_STAGES];
  logic [DEN_W-1:0]  rem_r  [DIV_STAGES];
  logic [QUOT_W-1:0] sh_r   [DIV_STAGES];
  logic [DEN_W-1:0]  den_r  [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    item_t             item_c;
    logic [DEN_W-1:0]  rem_in;
    logic [QUOT_W-1:0] sh_in;
    logic [DEN_W-1:0]  den_in;
    logic [DEN_W-1:0]  rem_nxt;
    logic [QUOT_W-1:0] sh_nxt;
    logic [DEN_W:0]    trial;

    // Stage input comes from the ports or from the previous stage.
    if (g == 0) begin : g_first
      assign item_c = item_i;
      assign rem_in = DEN_W'(num_i[NUM_W-1:QUOT_W]);
      assign sh_in  = num_i[QUOT_W-1:0];
      assign den_in = den_i;
    end else begin : g_next
      assign item_c = item_r[g-1];
      assign rem_in = rem_r[g-1];
      assign sh_in  = sh_r[g-1];
      assign den_in = den_r[g-1];
    end

    // Shift in one dividend bit per step and subtract where it fits.
    always_comb begin
      rem_nxt = rem_in;
      sh_nxt  = sh_in;
      trial   = '0;
      for (int s = 0; s < DIV_STEPS; s++) begin
        trial = {rem_nxt, sh_nxt[QUOT_W-1]};
        if (trial >= {1'b0, den_in}) begin
          trial  = trial - {1'b0, den_in};
          sh_nxt = {sh_nxt[QUOT_W-2:0], 1'b1};
        end else begin
          sh_nxt = {sh_nxt[QUOT_W-2:0], 1'b0};
        end
        rem_nxt = trial[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        item_r[g] <= '0;
      end else if (en) begin
        item_r[g] <= item_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_nxt;
        sh_r[g]  <= sh_nxt;
        den_r[g] <= den_in;
      end
    end
  end

  assign item_o = item_r[DIV_STAGES-1];
  assign quot_o = sh_r[DIV_STAGES-1];

endmodule

// ===== hw/rtl/wsg_sin.sv =====
// Pipelined sine of a 32-bit phase: quadrant fold, Q30 angle and a nested
// Taylor series with constant reciprocal divides. Depends on wsg_pkg.
module wsg_sin (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  wsg_pkg::item_t              item_i,
  input  logic [wsg_pkg::QUOT_W-1:0]  phase_i,
  output wsg_pkg::item_t              item_o,
  output logic signed [17:0]          sine_o
);
  import wsg_pkg::*;

  // Fold stage.
  item_t       fold_item_r;
  logic [1:0]  fold_q_r;
  logic [30:0] fold_r_r;
  logic [29:0] frac;
  logic [30:0] fold_r_nxt;

  // Angle and angle squared stages.
  item_t       ang_item_r;
  logic [1:0]  ang_q_r;
  logic [30:0] ang_a_r;
  logic [61:0] ang_prod;
  item_t       sq_item_r;
  logic [1:0]  sq_q_r;
  logic [30:0] sq_a_r;
  logic [31:0] sq_a2_r;
  logic [61:0] sq_prod;

  // Series stages: product then reciprocal divide, per term.
  item_t       pa_item_r [SER_LEN];
  logic [1:0]  pa_q_r    [SER_LEN];
  logic [30:0] pa_a_r    [SER_LEN];
  logic [31:0] pa_a2_r   [SER_LEN];
  logic [31:0] pa_x_r    [SER_LEN];
  item_t       pb_item_r [SER_LEN];
  logic [1:0]  pb_q_r    [SER_LEN];
  logic [30:0] pb_a_r    [SER_LEN];
  logic [31:0] pb_a2_r   [SER_LEN];
  logic [30:0] pb_h_r    [SER_LEN];

  // Final product and rounding stages.
  item_t       fin_item_r;
  logic [1:0]  fin_q_r;
  logic [30:0] fin_s_r;
  logic [61:0] fin_prod;
  item_t       out_item_r;
  logic signed [17:0] out_sine_r;
  logic [31:0] round_sum;
  logic [16:0] mag;

  // Fold the phase into the first quadrant.
  assign frac       = phase_i[29:0];
  assign fold_r_nxt = phase_i[30] ? (ONE_Q30 - {1'b0, frac}) : {1'b0, frac};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_item_r <= '0;
      ang_item_r  <= '0;
      sq_item_r   <= '0;
      fin_item_r  <= '0;
      out_item_r  <= '0;
    end else if (en) begin
      fold_item_r <= item_i;
      ang_item_r  <= fold_item_r;
      sq_item_r   <= ang_item_r;
      fin_item_r  <= pb_item_r[SER_LEN-1];
      out_item_r  <= fin_item_r;
    end
  end

  // Angle in Q30 radians, then its square.
  assign ang_prod = fold_r_r * HALF_PI_Q30;
  assign sq_prod  = ang_a_r * ang_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      fold_q_r <= phase_i[31:30];
      fold_r_r <= fold_r_nxt;
      ang_q_r  <= fold_q_r;
      ang_a_r  <= ang_prod[60:30];
      sq_q_r   <= ang_q_r;
      sq_a_r   <= ang_a_r;
      sq_a2_r  <= sq_prod[61:30];
    end
  end

  for (genvar g = 0; g < SER_LEN; g++) begin : g_term
    localparam int SH = 32 + SER_L[g];
    localparam logic [33:0] RECIP = 34'(((66'd1 << SH) / SER_K[g]) + 1);

    item_t       item_c;
    logic [1:0]  q_c;
    logic [30:0] a_c;
    logic [31:0] a2_c;
    logic [30:0] h_c;
    logic [62:0] xp;
    logic [65:0] yp;
    logic [29:0] y;

    if (g == 0) begin : g_first
      assign item_c = sq_item_r;
      assign q_c    = sq_q_r;
      assign a_c    = sq_a_r;
      assign a2_c   = sq_a2_r;
      assign h_c    = ONE_Q30;
    end else begin : g_next
      assign item_c = pb_item_r[g-1];
      assign q_c    = pb_q_r[g-1];
      assign a_c    = pb_a_r[g-1];
      assign a2_c   = pb_a2_r[g-1];
      assign h_c    = pb_h_r[g-1];
    end

    // Product a2*h in Q30, then floor division by the term's divisor.
    assign xp = a2_c * h_c;
    assign yp = pa_x_r[g] * RECIP;
    assign y  = 30'(yp >> SH);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pa_item_r[g] <= '0;
        pb_item_r[g] <= '0;
      end else if (en) begin
        pa_item_r[g] <= item_c;
        pb_item_r[g] <= pa_item_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pa_q_r[g]  <= q_c;
        pa_a_r[g]  <= a_c;
        pa_a2_r[g] <= a2_c;
        pa_x_r[g]  <= xp[61:30];
        pb_q_r[g]  <= pa_q_r[g];
        pb_a_r[g]  <= pa_a_r[g];
        pb_a2_r[g] <= pa_a2_r[g];
        pb_h_r[g]  <= ONE_Q30 - {1'b0, y};
      end
    end
  end

  // Sine in Q30, then rounded to the sample fraction and signed.
  assign fin_prod  = pb_a_r[SER_LEN-1] * pb_h_r[SER_LEN-1];
  assign round_sum = {1'b0, fin_s_r} + (32'd1 << (30 - FRAC_BITS - 1));
  assign mag       = round_sum[30 - FRAC_BITS +: 17];

  always_ff @(posedge clk) begin
    if (en) begin
      fin_q_r    <= pb_q_r[SER_LEN-1];
      fin_s_r    <= fin_prod[60:30];
      out_sine_r <= fin_q_r[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign item_o = out_item_r;
  assign sine_o = out_sine_r;

endmodule

// ===== hw/rtl/wavetable_sample_generator_core.sv =====
// Wavetable sample generator: one signed Q1.15 sample per table index.
// Depends on wsg_pkg, wsg_div and wsg_sin.
//
// Usage notes.
// The input channel carries in_sample_index; a transfer happens at a clock
// edge where in_valid is high and in_stall is low. The result channel carries
// out_sample_value and out_index_error under the same rule with out_valid and
// out_stall. Table length and wave shape are written through the cfg_ port
// (index 0 length, index 1 shape), which is always ready; write only while
// no item is in flight.
// From input transfer to result valid, an item passes the input and operand
// registers, the 16-stage divider, the 17-stage sine unit and the output
// register; every shape takes the same path so results stay in order.
// Throughput is one item per cycle while no result is held by the receiver.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Synchronous reset clears all valid bits, sets the length to 1024 and the
// shape to sine.
module wavetable_sample_generator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [wsg_pkg::INDEX_W-1:0]        in_sample_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [wsg_pkg::SAMPLE_W-1:0] out_sample_value,
  output logic                               out_index_error,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wsg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import wsg_pkg::*;

  logic                en;
  logic [LEN_W-1:0]    table_length_r;
  wave_shape_t         wave_shape_r;

  logic                in_vld_r;
  logic [INDEX_W-1:0]  in_idx_r;

  logic [LEN_W-1:0]    n_eff;
  logic [LEN_W-2:0]    half_n;
  logic [LEN_W-2:0]    rr;
  logic [INDEX_W-1:0]  idx;
  item_t               prep_nxt;
  logic [NUM_W-1:0]    num_nxt;
  logic [DEN_W-1:0]    den_nxt;
  item_t               prep_item_r;
  logic [NUM_W-1:0]    prep_num_r;
  logic [DEN_W-1:0]    prep_den_r;

  item_t               div_item;
  logic [QUOT_W-1:0]   div_quot;
  item_t               sin_in_item;
  item_t               sin_item;
  logic signed [17:0]  sine_val;

  logic signed [18:0]  v;
  logic signed [18:0]  t_s;
  logic signed [SAMPLE_W-1:0] sample_nxt;

  logic                out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                out_err_r;

  // The pipeline moves unless a finished result is held by the receiver.
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= 13'd1024;
      wave_shape_r   <= SHAPE_SINE;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TABLE_LENGTH) begin
        table_length_r <= cfg_data[LEN_W-1:0];
      end else if (cfg_index == REG_WAVE_SHAPE) begin
        wave_shape_r <= wave_shape_t'(cfg_data[1:0]);
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_idx_r <= in_sample_index;
    end
  end

  // Range check and divider operands for the chosen shape.
  assign idx    = in_idx_r;
  assign n_eff  = (table_length_r > MAX_LEN) ? MAX_LEN : table_length_r;
  assign half_n = n_eff[LEN_W-1:1];
  assign rr     = half_n + 12'd1;

  always_comb begin
    prep_nxt            = '0;
    prep_nxt.valid      = in_vld_r;
    prep_nxt.err        = ({1'b0, idx} >= n_eff);
    prep_nxt.shape      = wave_shape_r;
    prep_nxt.below_half = (idx < half_n);
    prep_nxt.rising     = (idx < rr);
    num_nxt             = '0;
    den_nxt             = '0;
    unique case (wave_shape_r)
      SHAPE_SINE: begin
        num_nxt = {idx, {QUOT_W{1'b0}}} + NUM_W'(half_n);
        den_nxt = DEN_W'(n_eff);
      end
      SHAPE_TRI: begin
        num_nxt = (NUM_W'(idx) << LIN_W) + NUM_W'(rr);
        den_nxt = {1'b0, rr, 1'b0};
      end
      SHAPE_SAW, SHAPE_SQUARE: begin
        num_nxt = (NUM_W'(idx) << LIN_W) + NUM_W'(n_eff);
        den_nxt = {n_eff, 1'b0};
      end
      default: begin
        num_nxt = '0;
        den_nxt = '0;
      end
    endcase
    // Keep the divider's remainder in range for indices that are errors.
    if (prep_nxt.err) begin
      num_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_item_r <= '0;
    end else if (en) begin
      prep_item_r <= prep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_num_r <= num_nxt;
      prep_den_r <= den_nxt;
    end
  end

  wsg_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .item_i (prep_item_r),
    .num_i  (prep_num_r),
    .den_i  (prep_den_r),
    .item_o (div_item),
    .quot_o (div_quot)
  );

  // The low quotient bits serve saw and triangle; the whole quotient is the phase.
  always_comb begin
    sin_in_item   = div_item;
    sin_in_item.t = div_quot[LIN_W-1:0];
  end

  wsg_sin u_sin (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .item_i  (sin_in_item),
    .phase_i (div_quot),
    .item_o  (sin_item),
    .sine_o  (sine_val)
  );

  // Shape select and saturation.
  assign t_s = $signed({2'b00, sin_item.t});

  always_comb begin
    v = '0;
    unique case (sin_item.shape)
      SHAPE_SINE:   v = 19'(sine_val);
      SHAPE_SAW:    v = t_s - 19'sd32768;
      SHAPE_TRI:    v = sin_item.rising ? (t_s - 19'sd32768) : (19'sd98304 - t_s);
      SHAPE_SQUARE: v = sin_item.below_half ? -19'sd32768 : 19'sd32767;
      default:      v = '0;
    endcase
    if (sin_item.err) begin
      sample_nxt = '0;
    end else if (v > 19'sd32767) begin
      sample_nxt = 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      sample_nxt = 16'sh8000;
    end else begin
      sample_nxt = v[SAMPLE_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sin_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sample_r <= sample_nxt;
      out_err_r    <= sin_item.err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_sample_r;
  assign out_index_error  = out_err_r;

endmodule

// ===== hw/rtl/wsg_checker.sv =====
// Port-level checks for the wavetable sample generator, bound to the top level.
// Depends only on the top level's ports.
module wsg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_sample_value,
  input logic               out_index_error
);

  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_value)
      && $stable(out_index_error))
    else $error("stalled result changed");

  // An index error always reads as a zero sample.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_error |-> out_sample_value == 16'sd0)
    else $error("index error with non-zero sample");

  // The input only backs up when the output is held.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // Nothing is offered in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind wavetable_sample_generator_core wsg_checker u_wsg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sample_value (out_sample_value),
  .out_index_error  (out_index_error)
);
